// ===== sv/assert_macros.svh =====
// assertion macros shared by the linear partition block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lpmm_pkg.sv =====
// shared types and constants of the linear partition block
package lpmm_pkg;

    localparam int WC_W = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic load;
        logic read;
        logic search_init;
        logic check;
        logic prime_first;
        logic prime_second;
        logic step;
        logic fit_update;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic mark_mode;
    } t_dp_stat;

endpackage

// ===== sv/linear_partition_min_max_top.sv =====
// top level of the linear partition min-max block
//
// Commands are taken at a clock edge with start high and busy low. A load
// (cmd 0) stores one page count while the store has room; a load with last
// high then holds busy while the limit is searched by bisection probes, at
// most as many as the bit length of the page total (33 at the default
// sizes). Each probe is one right-to-left greedy pass over the page store
// at one book per cycle through its single read port, and a final pass
// writes the cut marks. A read (cmd 1) puts its result word on the o_ ports
// for exactly one cycle, flagged by o_valid, on the cycle after; reads may
// follow back to back. The receiver cannot stall: a result word must be
// taken in the cycle it is shown. A read with no answer pending yields no
// word. The worker count is written through its own channel, always ready;
// the user must write it only while idle, which the block does not enforce.
module linear_partition_min_max_top #(
    parameter int MAX_BOOKS = 512,
    parameter int PAGE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cmd,
    input  logic [PAGE_BITS-1:0]                   i_pages,
    input  logic                                   i_last,
    output logic                                   o_valid,
    output logic [PAGE_BITS-1:0]                   o_pages_out,
    output logic                                   o_divider_before,
    output logic [PAGE_BITS+$clog2(MAX_BOOKS)-1:0] o_best_limit,
    output logic                                   o_last_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lpmm_pkg::WC_W-1:0]              i_cfg_worker_count
);

    lpmm_pkg::t_dp_cmd  w_cmd;
    lpmm_pkg::t_dp_stat w_stat;

    lpmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_last  (i_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    lpmm_dp #(
        .MAX_BOOKS (MAX_BOOKS),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_pages            (i_pages),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_worker_count (i_cfg_worker_count),
        .o_stat             (w_stat),
        .o_valid            (o_valid),
        .o_pages_out        (o_pages_out),
        .o_divider_before   (o_divider_before),
        .o_best_limit       (o_best_limit),
        .o_last_out         (o_last_out)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/lpmm_ram.sv =====
// generic simple dual-port ram with registered read
module lpmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lpmm_ctrl.sv =====
// controller state machine: load, search probes, marking pass, read
`include "assert_macros.svh"

module lpmm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_cmd,
    input  logic               i_last,
    input  lpmm_pkg::t_dp_stat i_stat,
    output lpmm_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_PRE1   = 3'd3;
    localparam logic [2:0] S_PRE2   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FIT    = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    lpmm_pkg::t_dp_cmd w_cmd;
    logic              w_last_load;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == lpmm_pkg::CMD_LOAD) begin
                        w_cmd.load = 1'b1;
                        if (i_last) begin
                            n_state = S_INIT;
                        end
                    end else begin
                        w_cmd.read = 1'b1;
                    end
                end
            end
            S_INIT: begin
                w_cmd.search_init = 1'b1;
                n_state           = S_CHECK;
            end
            S_CHECK: begin
                w_cmd.check = 1'b1;
                n_state     = S_PRE1;
            end
            S_PRE1: begin
                w_cmd.prime_first = 1'b1;
                n_state           = S_PRE2;
            end
            S_PRE2: begin
                w_cmd.prime_second = 1'b1;
                n_state            = S_SCAN;
            end
            S_SCAN: begin
                w_cmd.step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = i_stat.mark_mode ? S_FINISH : S_FIT;
                end
            end
            S_FIT: begin
                w_cmd.fit_update = 1'b1;
                n_state          = S_CHECK;
            end
            S_FINISH: begin
                w_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

    assign w_last_load = (r_state == S_IDLE) && i_start && (i_cmd == lpmm_pkg::CMD_LOAD)
                       && i_last;

    `ASSERT_NEXT(a_fit_back_to_check, r_state == S_FIT, r_state == S_CHECK)
    `ASSERT_NEXT(a_last_load_starts, w_last_load, o_busy)

endmodule

// ===== sv/lpmm_dp.sv =====
// datapath: page store, cut marks, greedy scan, search bounds, read-out
`include "assert_macros.svh"

module lpmm_dp #(
    parameter int MAX_BOOKS = 512,
    parameter int PAGE_BITS = 24
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  lpmm_pkg::t_dp_cmd                               i_cmd,
    input  logic [PAGE_BITS-1:0]                            i_pages,
    input  logic                                            i_cfg_valid,
    input  logic [lpmm_pkg::WC_W-1:0]                       i_cfg_worker_count,
    output lpmm_pkg::t_dp_stat                              o_stat,
    output logic                                            o_valid,
    output logic [PAGE_BITS-1:0]                            o_pages_out,
    output logic                                            o_divider_before,
    output logic [PAGE_BITS+$clog2(MAX_BOOKS)-1:0]          o_best_limit,
    output logic                                            o_last_out
);

    localparam int IDX_W = $clog2(MAX_BOOKS);
    localparam int CNT_W = $clog2(MAX_BOOKS + 1);
    localparam int SUM_W = PAGE_BITS + IDX_W;
    localparam int WC_W  = lpmm_pkg::WC_W;
    localparam int CMP_W = (CNT_W > WC_W) ? CNT_W : WC_W;

    // control registers
    logic [WC_W-1:0]  r_worker;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_total;
    logic             r_ready;
    logic             r_closed;
    logic [CNT_W-1:0] r_ridx;
    logic [WC_W-1:0]  r_spare;
    logic [SUM_W-1:0] r_limit;
    logic [SUM_W-1:0] r_lo;
    logic [SUM_W-1:0] r_hi;
    logic             r_mark;
    logic             r_out_valid;

    // scan and output payload
    logic [SUM_W-1:0]     r_probe;
    logic [PAGE_BITS-1:0] r_cur;
    logic [SUM_W-1:0]     r_acc;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_shares;
    logic                 r_fail;
    logic                 r_out_first;
    logic                 r_out_last;

    logic [CNT_W-1:0]     w_eff_cnt;
    logic [SUM_W-1:0]     w_eff_total;
    logic                 w_store_ok;
    logic                 w_read_ok;
    logic [IDX_W-1:0]     w_raddr;
    logic [PAGE_BITS-1:0] w_page_rd;
    logic                 w_cut_rd;
    logic [SUM_W-1:0]     w_acc_new;
    logic [SUM_W:0]       w_sum3;
    logic                 w_cut;
    logic                 w_too_big;
    logic                 w_fits;
    logic [SUM_W:0]       w_mid_sum;
    logic [SUM_W-1:0]     w_mid;
    logic                 w_more;
    logic [CMP_W-1:0]     w_shares_ext;
    logic [CMP_W-1:0]     w_worker_ext;
    logic                 w_spare_use;

    assign w_eff_cnt   = r_closed ? '0 : r_count;
    assign w_eff_total = r_closed ? '0 : r_total;
    assign w_store_ok  = (w_eff_cnt < CNT_W'(MAX_BOOKS));
    assign w_read_ok   = r_ready && (r_ridx < r_count);

    always_comb begin
        w_raddr = r_ridx[IDX_W-1:0];
        if (i_cmd.prime_first) begin
            w_raddr = IDX_W'(r_count - CNT_W'(1));
        end else if (i_cmd.prime_second) begin
            w_raddr = r_idx - IDX_W'(1);
        end else if (i_cmd.step) begin
            w_raddr = r_idx - IDX_W'(2);
        end
    end

    lpmm_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_BOOKS)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_store_ok),
        .i_waddr (w_eff_cnt[IDX_W-1:0]),
        .i_wdata (i_pages),
        .i_raddr (w_raddr),
        .o_rdata (w_page_rd)
    );

    lpmm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BOOKS)
    ) u_cut_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.step && r_mark),
        .i_waddr (r_idx),
        .i_wdata (w_cut),
        .i_raddr (r_ridx[IDX_W-1:0]),
        .o_rdata (w_cut_rd)
    );

    // greedy step for book r_idx, w_page_rd holds the book to its left
    assign w_acc_new = r_acc + SUM_W'(r_cur);
    assign w_sum3    = {1'b0, w_acc_new} + (SUM_W + 1)'(w_page_rd);
    assign w_cut     = (r_idx != '0) && (w_sum3 > {1'b0, r_probe});
    assign w_too_big = (r_probe < SUM_W'(r_cur));

    assign w_shares_ext = CMP_W'(r_shares);
    assign w_worker_ext = CMP_W'(r_worker);
    assign w_fits       = !r_fail && (w_shares_ext <= w_worker_ext);

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[SUM_W:1];
    assign w_more    = ({1'b0, r_hi} > ({1'b0, r_lo} + (SUM_W + 1)'(1)));

    assign w_spare_use = r_out_valid && !w_cut_rd && !r_out_first && (r_spare != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker    <= WC_W'(1);
            r_count     <= '0;
            r_total     <= '0;
            r_ready     <= 1'b0;
            r_closed    <= 1'b0;
            r_ridx      <= '0;
            r_spare     <= '0;
            r_limit     <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_mark      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_worker <= i_cfg_worker_count;
            end
            r_out_valid <= i_cmd.read && w_read_ok;
            if (i_cmd.load) begin
                r_closed <= 1'b0;
                if (r_closed) begin
                    r_ridx  <= '0;
                    r_ready <= 1'b0;
                end
                if (w_store_ok) begin
                    r_count <= w_eff_cnt + CNT_W'(1);
                    r_total <= w_eff_total + SUM_W'(i_pages);
                end else begin
                    r_count <= w_eff_cnt;
                    r_total <= w_eff_total;
                end
            end
            if (i_cmd.read && w_read_ok) begin
                r_ridx <= r_ridx + CNT_W'(1);
                if (r_ridx + CNT_W'(1) == r_count) begin
                    r_ready <= 1'b0;
                end
            end
            if (i_cmd.search_init) begin
                r_lo <= '0;
                r_hi <= r_total;
            end
            if (i_cmd.check) begin
                r_mark <= !w_more;
                if (!w_more) begin
                    r_limit <= r_hi;
                end
            end
            if (i_cmd.fit_update) begin
                if (w_fits) begin
                    r_hi <= r_probe;
                end else begin
                    r_lo <= r_probe;
                end
            end
            if (i_cmd.finish) begin
                r_ready  <= 1'b1;
                r_closed <= 1'b1;
                r_ridx   <= '0;
                r_spare  <= (w_worker_ext > w_shares_ext)
                          ? WC_W'(w_worker_ext - w_shares_ext) : '0;
            end else if (w_spare_use) begin
                r_spare <= r_spare - WC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_probe <= w_more ? w_mid : r_hi;
        end
        if (i_cmd.prime_first) begin
            r_idx    <= IDX_W'(r_count - CNT_W'(1));
            r_acc    <= '0;
            r_shares <= CNT_W'(1);
            r_fail   <= 1'b0;
        end
        if (i_cmd.prime_second) begin
            r_cur <= w_page_rd;
        end
        if (i_cmd.step) begin
            r_cur <= w_page_rd;
            r_idx <= r_idx - IDX_W'(1);
            r_acc <= w_cut ? '0 : w_acc_new;
            if (w_cut) begin
                r_shares <= r_shares + CNT_W'(1);
            end
            if (w_too_big) begin
                r_fail <= 1'b1;
            end
        end
        if (i_cmd.read) begin
            r_out_first <= (r_ridx == '0);
            r_out_last  <= (r_ridx + CNT_W'(1) == r_count);
        end
    end

    assign o_stat.scan_last = (r_idx == '0);
    assign o_stat.mark_mode = r_mark;

    assign o_valid          = r_out_valid;
    assign o_pages_out      = w_page_rd;
    assign o_divider_before = w_cut_rd || (!r_out_first && (r_spare != '0));
    assign o_best_limit     = r_limit;
    assign o_last_out       = r_out_last;

    `ASSERT_IMPL(a_ready_in_range, r_ready, r_ridx < r_count)
    `ASSERT_IMPL(a_bounds_ordered, 1'b1, r_lo <= r_hi)
    `ASSERT_IMPL(a_word_after_read, r_out_valid, $past(i_cmd.read))

endmodule
